>>> rtl/core/wopu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table for the odometry block.
package wopu_pkg;

  localparam int WORD_W = 32;
  localparam int CORDIC_STEPS_DEFAULT = 24;
  localparam int ITER_W = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_PER_TICK  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_WHEELBASE  = 1'd1;

  localparam logic [WORD_W-1:0] DIST_PER_TICK_RESET = 32'd7906077;
  localparam logic [WORD_W-1:0] INV_WHEELBASE_RESET = 32'd16777216;
  localparam logic [WORD_W-1:0] RAD_TO_BAM          = 32'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN        = 34'sd652032874;
  localparam logic [39:0] TURN_CLAMP                = 40'hFF_FFFF_FFFF;

  // Multiply-shift operations issued by the sequencer, in execution order.
  typedef enum logic [2:0] {
    MOP_DIST  = 3'd0,
    MOP_TURN  = 3'd1,
    MOP_RAD   = 3'd2,
    MOP_BAM   = 3'd3,
    MOP_STEPX = 3'd4,
    MOP_STEPY = 3'd5
  } mop_t;

  typedef struct packed {
    logic              load;
    logic              delta;
    logic              mul_lo;
    logic              mul_hi;
    logic              mul_wb;
    mop_t              op;
    logic              cordic_init;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              cordic_map;
    logic              commit;
  } dp_cmd_t;

  // atan(2^-i) as a binary angle (full turn = 2^32).
  function automatic logic [WORD_W-1:0] atan_bam(input logic [ITER_W-1:0] i);
    logic [WORD_W-1:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/wopu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for encoder samples and pose results.
interface wopu_sample_if;
  logic                           valid;
  logic                           ready;
  logic [wopu_pkg::WORD_W-1:0]    sample_time_ms;
  logic signed [wopu_pkg::WORD_W-1:0] front_left_ticks;
  logic signed [wopu_pkg::WORD_W-1:0] front_right_ticks;
  logic signed [wopu_pkg::WORD_W-1:0] back_left_ticks;
  logic signed [wopu_pkg::WORD_W-1:0] back_right_ticks;

  modport source (output valid, sample_time_ms, front_left_ticks, front_right_ticks,
                  back_left_ticks, back_right_ticks, input ready);
  modport sink (input valid, sample_time_ms, front_left_ticks, front_right_ticks,
                back_left_ticks, back_right_ticks, output ready);
endinterface

interface wopu_pose_if;
  logic                               valid;
  logic                               ready;
  logic [wopu_pkg::WORD_W-1:0]        pose_time_ms;
  logic signed [wopu_pkg::WORD_W-1:0] position_x;
  logic signed [wopu_pkg::WORD_W-1:0] position_y;
  logic [wopu_pkg::WORD_W-1:0]        heading_angle;

  modport source (output valid, pose_time_ms, position_x, position_y, heading_angle,
                  input ready);
  modport sink (input valid, pose_time_ms, position_x, position_y, heading_angle,
                output ready);
endinterface

>>> rtl/core/wopu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the odometry update: multiply steps, CORDIC iterations, result hand-off.
module wopu_ctrl #(
  parameter int CORDIC_STEPS = wopu_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wopu_pkg::dp_cmd_t   cmd
);

  localparam int IW = $clog2(CORDIC_STEPS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DELTA  = 9'b000000010,
    S_MUL_LO = 9'b000000100,
    S_MUL_HI = 9'b000001000,
    S_MUL_WB = 9'b000010000,
    S_CINIT  = 9'b000100000,
    S_CSTEP  = 9'b001000000,
    S_CMAP   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t          state, state_next;
  wopu_pkg::mop_t  op, op_next;
  logic [IW-1:0]   iter, iter_next;
  logic            have_previous, have_previous_next;
  logic            out_valid_next;
  logic            accept;
  logic            slot_free;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  function automatic wopu_pkg::mop_t following_op(input wopu_pkg::mop_t o);
    wopu_pkg::mop_t n;
    unique case (o)
      wopu_pkg::MOP_DIST:  n = wopu_pkg::MOP_TURN;
      wopu_pkg::MOP_TURN:  n = wopu_pkg::MOP_RAD;
      wopu_pkg::MOP_RAD:   n = wopu_pkg::MOP_BAM;
      wopu_pkg::MOP_STEPX: n = wopu_pkg::MOP_STEPY;
      default:             n = wopu_pkg::MOP_DIST;
    endcase
    return n;
  endfunction

  always_comb begin
    state_next         = state;
    op_next            = op;
    iter_next          = iter;
    have_previous_next = have_previous;
    in_ready           = 1'b0;
    cmd                = '0;
    cmd.op             = op;
    cmd.iter           = wopu_pkg::ITER_W'(iter);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.load = 1'b1;
          if (have_previous) begin
            state_next = S_DELTA;
          end else begin
            have_previous_next = 1'b1;
          end
        end
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        op_next    = wopu_pkg::MOP_DIST;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_WB;
      end
      S_MUL_WB: begin
        cmd.mul_wb = 1'b1;
        if (op == wopu_pkg::MOP_BAM) begin
          state_next = S_CINIT;
        end else if (op == wopu_pkg::MOP_STEPY) begin
          state_next = S_FINISH;
        end else begin
          op_next    = following_op(op);
          state_next = S_MUL_LO;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        iter_next       = '0;
        state_next      = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cordic_step = 1'b1;
        if (iter == IW'(CORDIC_STEPS - 1)) begin
          state_next = S_CMAP;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_CMAP: begin
        cmd.cordic_map = 1'b1;
        op_next        = wopu_pkg::MOP_STEPX;
        state_next     = S_MUL_LO;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= wopu_pkg::MOP_DIST;
      iter          <= '0;
      have_previous <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      op            <= op_next;
      iter          <= iter_next;
      have_previous <= have_previous_next;
      out_valid     <= out_valid_next;
    end
  end

endmodule

>>> rtl/core/wopu_datapath.sv
`timescale 1ns / 1ps
// Odometry datapath: wheel deltas, shared multiply-shift unit, CORDIC, pose registers.
module wopu_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [wopu_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wopu_pkg::WORD_W-1:0]           cfg_data,
  input  wopu_pkg::dp_cmd_t                     cmd,
  input  logic [wopu_pkg::WORD_W-1:0]           sample_time_ms,
  input  logic signed [wopu_pkg::WORD_W-1:0]    front_left_ticks,
  input  logic signed [wopu_pkg::WORD_W-1:0]    front_right_ticks,
  input  logic signed [wopu_pkg::WORD_W-1:0]    back_left_ticks,
  input  logic signed [wopu_pkg::WORD_W-1:0]    back_right_ticks,
  output logic [wopu_pkg::WORD_W-1:0]           pose_time_ms,
  output logic signed [wopu_pkg::WORD_W-1:0]    position_x,
  output logic signed [wopu_pkg::WORD_W-1:0]    position_y,
  output logic [wopu_pkg::WORD_W-1:0]           heading_angle
);

  logic [31:0] meters_per_tick, inverse_wheelbase;
  logic [31:0] prev_fl, prev_fr, prev_bl, prev_br;
  logic [31:0] time_reg;
  logic [32:0] side_l, side_r;
  logic        ssum_neg, sdiff_neg;
  logic [33:0] ssum_mag, sdiff_mag;
  logic [46:0] dist_mag;
  logic [39:0] turn_h;
  logic [47:0] rad;
  logic [31:0] dth, half;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0] pose_heading;
  logic [1:0]  quarter;
  logic signed [33:0] cx, cy, cz;
  logic        cs_neg, sn_neg;
  logic [31:0] cs_mag, sn_mag;
  logic signed [49:0] step_x, step_y;

  // multiply unit
  logic [47:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] p_lo;
  logic [47:0] p_hi;
  logic [79:0] full;
  logic [79:0] shifted;
  logic [55:0] r;

  logic [31:0] dfl, dfr, dbl, dbr;
  logic [33:0] ssum, sdiff;
  logic [31:0] mid, qsum, resid;
  logic signed [33:0] dx, dy, cmap_c, cmap_s;
  logic [31:0] atan_i;
  logic signed [50:0] sum_x, sum_y;
  logic signed [31:0] new_x, new_y;
  logic [31:0] new_heading;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] o;
    if (v > 51'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (v < -51'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] abs34(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? -v : v;
    return m[31:0];
  endfunction

  assign dfl = front_left_ticks - prev_fl;
  assign dfr = front_right_ticks - prev_fr;
  assign dbl = back_left_ticks - prev_bl;
  assign dbr = back_right_ticks - prev_br;

  assign ssum  = {side_l[32], side_l} + {side_r[32], side_r};
  assign sdiff = {side_r[32], side_r} - {side_l[32], side_l};

  always_comb begin
    unique case (cmd.op)
      wopu_pkg::MOP_DIST:  begin mul_a = {14'b0, ssum_mag};  mul_b = meters_per_tick; end
      wopu_pkg::MOP_TURN:  begin mul_a = {14'b0, sdiff_mag}; mul_b = meters_per_tick; end
      wopu_pkg::MOP_RAD:   begin mul_a = {8'b0, turn_h};     mul_b = inverse_wheelbase; end
      wopu_pkg::MOP_BAM:   begin mul_a = rad;                mul_b = wopu_pkg::RAD_TO_BAM; end
      wopu_pkg::MOP_STEPX: begin mul_a = {1'b0, dist_mag};   mul_b = cs_mag; end
      wopu_pkg::MOP_STEPY: begin mul_a = {1'b0, dist_mag};   mul_b = sn_mag; end
      default:             begin mul_a = '0;                 mul_b = '0; end
    endcase
  end

  assign full = {p_hi, 32'b0} + {16'b0, p_lo};

  always_comb begin
    unique case (cmd.op)
      wopu_pkg::MOP_DIST:  shifted = full >> 18;
      wopu_pkg::MOP_TURN:  shifted = full >> 9;
      wopu_pkg::MOP_RAD,
      wopu_pkg::MOP_BAM:   shifted = full >> 24;
      default:             shifted = full >> 30;
    endcase
  end

  assign r = shifted[55:0];

  // CORDIC
  assign mid    = pose_heading + half;
  assign qsum   = mid + 32'h2000_0000;
  assign resid  = mid - {qsum[31:30], 30'b0};
  assign dx     = cy >>> cmd.iter;
  assign dy     = cx >>> cmd.iter;
  assign atan_i = wopu_pkg::atan_bam(cmd.iter);

  always_comb begin
    unique case (quarter)
      2'd0: begin cmap_c = cx;  cmap_s = cy;  end
      2'd1: begin cmap_c = -cy; cmap_s = cx;  end
      2'd2: begin cmap_c = -cx; cmap_s = -cy; end
      default: begin cmap_c = cy; cmap_s = -cx; end
    endcase
  end

  assign sum_x       = {{19{pose_x[31]}}, pose_x} + {step_x[49], step_x};
  assign sum_y       = {{19{pose_y[31]}}, pose_y} + {step_y[49], step_y};
  assign new_x       = sat32(sum_x);
  assign new_y       = sat32(sum_y);
  assign new_heading = pose_heading + dth;

  always_ff @(posedge clk) begin
    if (rst) begin
      meters_per_tick   <= wopu_pkg::DIST_PER_TICK_RESET;
      inverse_wheelbase <= wopu_pkg::INV_WHEELBASE_RESET;
      prev_fl      <= '0;
      prev_fr      <= '0;
      prev_bl      <= '0;
      prev_br      <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wopu_pkg::CFG_DIST_PER_TICK) begin
          meters_per_tick <= cfg_data;
        end else begin
          inverse_wheelbase <= cfg_data;
        end
      end
      if (cmd.load) begin
        prev_fl <= front_left_ticks;
        prev_fr <= front_right_ticks;
        prev_bl <= back_left_ticks;
        prev_br <= back_right_ticks;
      end
      if (cmd.commit) begin
        pose_x       <= new_x;
        pose_y       <= new_y;
        pose_heading <= new_heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_reg <= sample_time_ms;
      side_l   <= {dfl[31], dfl} + {dbl[31], dbl};
      side_r   <= {dfr[31], dfr} + {dbr[31], dbr};
    end
    if (cmd.delta) begin
      ssum_neg  <= ssum[33];
      ssum_mag  <= ssum[33] ? -ssum : ssum;
      sdiff_neg <= sdiff[33];
      sdiff_mag <= sdiff[33] ? -sdiff : sdiff;
    end
    if (cmd.mul_lo) begin
      p_lo <= 64'(mul_a[31:0]) * 64'(mul_b);
    end
    if (cmd.mul_hi) begin
      p_hi <= 48'(mul_a[47:32]) * 48'(mul_b);
    end
    if (cmd.mul_wb) begin
      unique case (cmd.op)
        wopu_pkg::MOP_DIST: dist_mag <= r[46:0];
        wopu_pkg::MOP_TURN: turn_h <= (r[55:40] != 16'd0) ? wopu_pkg::TURN_CLAMP : r[39:0];
        wopu_pkg::MOP_RAD:  rad <= r[47:0];
        wopu_pkg::MOP_BAM: begin
          dth  <= sdiff_neg ? -r[31:0] : r[31:0];
          half <= sdiff_neg ? -r[32:1] : r[32:1];
        end
        wopu_pkg::MOP_STEPX:
          step_x <= (ssum_neg ^ cs_neg) ? -{1'b0, r[48:0]} : {1'b0, r[48:0]};
        default:
          step_y <= (ssum_neg ^ sn_neg) ? -{1'b0, r[48:0]} : {1'b0, r[48:0]};
      endcase
    end
    if (cmd.cordic_init) begin
      quarter <= qsum[31:30];
      cz      <= {{2{resid[31]}}, resid};
      cx      <= wopu_pkg::CORDIC_GAIN;
      cy      <= '0;
    end
    if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - {2'b0, atan_i};
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + {2'b0, atan_i};
      end
    end
    if (cmd.cordic_map) begin
      cs_neg <= cmap_c[33];
      cs_mag <= abs34(cmap_c);
      sn_neg <= cmap_s[33];
      sn_mag <= abs34(cmap_s);
    end
    if (cmd.commit) begin
      pose_time_ms  <= time_reg;
      position_x    <= new_x;
      position_y    <= new_y;
      heading_angle <= new_heading;
    end
  end

endmodule

>>> rtl/core/wheel_odometry_pose_update.sv
`timescale 1ns / 1ps
// Top level of the differential-drive wheel odometry pose update.
//
// Usage:
//   sample (sink): one transfer per encoder sample: timestamp and four absolute
//     wheel counts (front left/right, back left/right).
//   pose (source): one transfer per sample except the first after reset,
//     carrying the sample's timestamp, x/y in Q16.16 meters (saturating) and
//     heading as a 32-bit binary angle.
//   cfg_we/cfg_index/cfg_data: register writes (0 = distance per tick, Q0.32;
//     1 = inverse wheelbase, Q8.24). Write only while the block is idle.
// Sequence: after the sample transfer the block forms the wheel deltas, runs
//   six passes through the shared multiply-shift unit (distance, turn, radians,
//   binary angle, then after the iterative CORDIC the x and y steps) and commits
//   the result. One sample is in work at a time; the first sample after reset
//   only stores the counts.
// Reset (rst, synchronous): pose and stored counts clear, registers reload
//   their defaults, no result is pending.
// Stall: the result sits in an output register; a new sample is taken while it
//   waits, and the next result holds in its final step until the slot frees.
module wheel_odometry_pose_update #(
  parameter int CORDIC_STEPS = wopu_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wopu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wopu_pkg::WORD_W-1:0]       cfg_data,
  wopu_sample_if.sink                       sample,
  wopu_pose_if.source                       pose
);

  wopu_pkg::dp_cmd_t cmd;

  // Sequencer: owns the handshake, the first-sample flag and step counting.
  wopu_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .cmd       (cmd)
  );

  // Arithmetic: deltas, multiply-shift chain, CORDIC, pose and output registers.
  wopu_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sample_time_ms    (sample.sample_time_ms),
    .front_left_ticks  (sample.front_left_ticks),
    .front_right_ticks (sample.front_right_ticks),
    .back_left_ticks   (sample.back_left_ticks),
    .back_right_ticks  (sample.back_right_ticks),
    .pose_time_ms      (pose.pose_time_ms),
    .position_x        (pose.position_x),
    .position_y        (pose.position_y),
    .heading_angle     (pose.heading_angle)
  );

endmodule

>>> test/wheel_odometry_pose_update_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wheel odometry pose update block.
module wheel_odometry_pose_update_test;

  localparam int STEPS = wopu_pkg::CORDIC_STEPS_DEFAULT;
  localparam int LATENCY = STEPS + 23;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [31:0] fl;
    logic signed [31:0] fr;
    logic signed [31:0] bl;
    logic signed [31:0] br;
  } sample_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        heading;
  } pose_t;

  // Odometry predictor plus the queue of poses still to arrive.
  class pose_scoreboard;
    logic [31:0]        dist_per_tick = wopu_pkg::DIST_PER_TICK_RESET;
    logic [31:0]        inv_wheelbase = wopu_pkg::INV_WHEELBASE_RESET;
    logic [31:0]        last_counts[4] = '{0, 0, 0, 0};
    bit                 primed;
    logic signed [31:0] px, py;
    logic [31:0]        heading;
    pose_t              pending_poses[$];
    int                 errors;

    function automatic logic [63:0] mul_shr(logic [63:0] a, logic [31:0] b, int s);
      logic [127:0] p;
      p = {64'b0, a} * {96'b0, b};
      p = p >> s;
      return p[63:0];
    endfunction

    function automatic logic [63:0] abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic longint smul_shr(longint a, longint b, int s);
      logic [63:0] m;
      logic [63:0] bm;
      bm = abs64(b);
      m = mul_shr(abs64(a), bm[31:0], s);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Rotation CORDIC on the residual after removing the nearest quarter turn.
    function automatic void sin_cos(logic [31:0] angle, output longint c, output longint s);
      logic [31:0]        shifted, resid;
      logic [1:0]         quad;
      logic signed [31:0] r;
      longint             x, y, z, dx, dy;
      shifted = angle + 32'h2000_0000;
      quad = shifted[31:30];
      resid = angle - {quad, 30'b0};
      r = resid;
      z = r;
      x = wopu_pkg::CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(wopu_pkg::atan_bam(i[wopu_pkg::ITER_W-1:0]));
        end else begin
          x += dx; y -= dy; z += longint'(wopu_pkg::atan_bam(i[wopu_pkg::ITER_W-1:0]));
        end
      end
      case (quad)
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function automatic void write_reg(logic [wopu_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] v);
      if (idx == wopu_pkg::CFG_DIST_PER_TICK) dist_per_tick = v;
      else inv_wheelbase = v;
    endfunction

    function automatic void note_sample(sample_t smp);
      logic signed [31:0] w[4];
      logic [31:0]        cur[4];
      longint             sl, sr, ssum, sdiff, travel, c, s;
      logic [63:0]        dm, h, rad, bam;
      logic [31:0]        dth, half;
      pose_t              p;
      cur = '{smp.fl, smp.fr, smp.bl, smp.br};
      if (primed) begin
        for (int k = 0; k < 4; k++) w[k] = cur[k] - last_counts[k];
        sl = longint'(w[0]) + longint'(w[2]);
        sr = longint'(w[1]) + longint'(w[3]);
        ssum = sl + sr;
        sdiff = sr - sl;
        dm = mul_shr(abs64(ssum), dist_per_tick, 18);
        travel = ssum < 0 ? -longint'(dm) : longint'(dm);
        h = mul_shr(abs64(sdiff), dist_per_tick, 9);
        if (h > {24'b0, wopu_pkg::TURN_CLAMP}) h = {24'b0, wopu_pkg::TURN_CLAMP};
        rad = mul_shr(h, inv_wheelbase, 24);
        bam = mul_shr(rad, wopu_pkg::RAD_TO_BAM, 24);
        dth = bam[31:0];
        half = bam[32:1];
        if (sdiff < 0) begin
          dth = -dth;
          half = -half;
        end
        sin_cos(heading + half, c, s);
        px = sat(longint'(px) + smul_shr(travel, c, 30));
        py = sat(longint'(py) + smul_shr(travel, s, 30));
        heading = heading + dth;
        p.time_ms = smp.time_ms;
        p.x = px;
        p.y = py;
        p.heading = heading;
        pending_poses.push_back(p);
      end
      primed = 1;
      last_counts = cur;
    endfunction

    function automatic void check_pose(pose_t got);
      pose_t exp_p;
      if (pending_poses.size() == 0) begin
        $error("unexpected pose transfer: time %0d", got.time_ms);
        errors++;
        return;
      end
      exp_p = pending_poses.pop_front();
      if (got.time_ms !== exp_p.time_ms) begin
        $error("pose_time_ms: expected %0d, got %0d", exp_p.time_ms, got.time_ms);
        errors++;
      end
      if (got.x !== exp_p.x) begin
        $error("position_x: expected %0d, got %0d", exp_p.x, got.x);
        errors++;
      end
      if (got.y !== exp_p.y) begin
        $error("position_y: expected %0d, got %0d", exp_p.y, got.y);
        errors++;
      end
      if (got.heading !== exp_p.heading) begin
        $error("heading_angle: expected %0h, got %0h", exp_p.heading, got.heading);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [wopu_pkg::CFG_INDEX_W-1:0] cfg_index = wopu_pkg::CFG_DIST_PER_TICK;
  logic [31:0] cfg_data = '0;

  wopu_sample_if smp_ch();
  wopu_pose_if   pose_ch();

  wheel_odometry_pose_update i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   (smp_ch.sink),
    .pose     (pose_ch.source)
  );

  pose_scoreboard sb = new();

  // idle rates in percent; hold_ready forces a long receiver stall
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_ready = 0;
  logic start_hold = 0;
  int  cycles = 0;
  logic [31:0] counts[4] = '{0, 0, 0, 0};
  logic [31:0] stamp = 0;

  always #1 clk = ~clk;

  initial begin
    smp_ch.valid = 0;
    smp_ch.sample_time_ms = '0;
    smp_ch.front_left_ticks = '0;
    smp_ch.front_right_ticks = '0;
    smp_ch.back_left_ticks = '0;
    smp_ch.back_right_ticks = '0;
    pose_ch.ready = 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Pose receiver: check each transfer, then pick next ready.
  always @(posedge clk) begin
    if (!rst && pose_ch.valid && pose_ch.ready)
      sb.check_pose({pose_ch.pose_time_ms, pose_ch.position_x, pose_ch.position_y,
                     pose_ch.heading_angle});
    if (rst || hold_ready) pose_ch.ready <= 0;
    else pose_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps pushing.
  initial begin
    @(posedge start_hold);
    @(posedge clk);
    hold_ready <= 1;
    repeat (400) @(posedge clk);
    hold_ready <= 0;
  end

  // Present one sample and wait for its transfer; valid stays up for back-to-back.
  task automatic send_sample(logic [31:0] t, logic [31:0] fl, logic [31:0] fr,
                             logic [31:0] bl, logic [31:0] br);
    if ($urandom_range(99) < send_idle_pct) begin
      smp_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    smp_ch.valid <= 1;
    smp_ch.sample_time_ms <= t;
    smp_ch.front_left_ticks <= fl;
    smp_ch.front_right_ticks <= fr;
    smp_ch.back_left_ticks <= bl;
    smp_ch.back_right_ticks <= br;
    do @(posedge clk); while (!smp_ch.ready);
    sb.note_sample({t, fl, fr, bl, br});
    counts = '{fl, fr, bl, br};
  endtask

  // Idle the input, drain all poses, then let any count-only sample settle.
  task automatic wait_drained();
    smp_ch.valid <= 0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [wopu_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  // Step each wheel by a small random amount, mostly forward; rarely a wild jump.
  task automatic send_motion();
    logic [31:0] nxt[4];
    int fwd, turn;
    stamp = stamp + $urandom_range(1, 20);
    if ($urandom_range(99) < 4) begin
      for (int k = 0; k < 4; k++) nxt[k] = $urandom;
    end else begin
      fwd = $urandom_range(0, 4000) - 1000;
      turn = $urandom_range(0, 600) - 300;
      nxt[0] = counts[0] + fwd - turn + $urandom_range(0, 6) - 3;
      nxt[2] = counts[2] + fwd - turn + $urandom_range(0, 6) - 3;
      nxt[1] = counts[1] + fwd + turn + $urandom_range(0, 6) - 3;
      nxt[3] = counts[3] + fwd + turn + $urandom_range(0, 6) - 3;
    end
    send_sample(($urandom_range(99) < 3) ? $urandom : stamp, nxt[0], nxt[1], nxt[2], nxt[3]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Defaults written explicitly; first sample only primes the counts.
    write_reg(wopu_pkg::CFG_DIST_PER_TICK, wopu_pkg::DIST_PER_TICK_RESET);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, wopu_pkg::INV_WHEELBASE_RESET);
    send_sample(32'd0, 0, 0, 0, 0);
    // straight, in place left and right turns, reverse
    send_sample(32'd1, 1000, 1000, 1000, 1000);
    send_sample(32'd2, 900, 1100, 900, 1100);
    send_sample(32'd3, 1100, 900, 1100, 900);
    send_sample(32'd4, 0, 0, 0, 0);
    // wrap at the 32-bit count boundary in both directions
    send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'd6, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    // huge turn gets clamped; repeated huge travel drives x/y into saturation
    send_sample(32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE);
    for (int i = 0; i < 4; i++)
      send_sample(32'd8 + i, counts[0] + 32'h3FFF_FFFF, counts[1] + 32'h3FFF_FFFF,
                  counts[2] + 32'h3FFF_FFFF, counts[3] + 32'h3FFF_FFFF);
    for (int i = 0; i < 4; i++)
      send_sample(32'd12 + i, counts[0] - 32'h3FFF_FFFF, counts[1] - 32'h3FFF_FFFF,
                  counts[2] - 32'h3FFF_FFFF, counts[3] - 32'h3FFF_FFFF);
    wait_drained();

    // Register extremes, including zero (no motion / no turning).
    write_reg(wopu_pkg::CFG_DIST_PER_TICK, 32'hFFFF_FFFF);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, 32'hFFFF_FFFF);
    send_sample(32'd20, counts[0] + 3, counts[1] + 90000, counts[2] - 7, counts[3] + 50);
    send_sample(32'd21, counts[0] - 1, counts[1] + 1, counts[2], counts[3]);
    wait_drained();
    write_reg(wopu_pkg::CFG_DIST_PER_TICK, 32'd0);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, 32'd1);
    send_sample(32'd22, counts[0] + 500, counts[1] + 800, counts[2] + 500, counts[3] + 800);
    wait_drained();
    write_reg(wopu_pkg::CFG_DIST_PER_TICK, 32'd1);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, 32'd0);
    send_sample(32'd23, counts[0] + 32'h1000_0000, counts[1] - 20, counts[2] + 9, counts[3]);
    wait_drained();

    // Random traffic: sender-light idling, receiver-heavy; includes long receiver stall.
    write_reg(wopu_pkg::CFG_DIST_PER_TICK, wopu_pkg::DIST_PER_TICK_RESET);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, wopu_pkg::INV_WHEELBASE_RESET);
    send_idle_pct = 12;
    recv_idle_pct = 63;
    start_hold <= 1;
    for (int i = 0; i < 500; i++) begin
      send_motion();
      if (i == 250) begin
        // sender pause until every pose is back
        smp_ch.valid <= 0;
        while (sb.pending_poses.size() != 0) @(posedge clk);
      end
    end
    wait_drained();

    write_reg(wopu_pkg::CFG_DIST_PER_TICK, $urandom);
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, $urandom_range(32'h0010_0000, 32'h0800_0000));
    send_idle_pct = 63;
    recv_idle_pct = 12;
    for (int i = 0; i < 500; i++) send_motion();
    wait_drained();

    write_reg(wopu_pkg::CFG_DIST_PER_TICK, $urandom_range(1, 32'h0100_0000));
    write_reg(wopu_pkg::CFG_INV_WHEELBASE, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 500; i++) send_motion();
    wait_drained();

    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
